>>> hdl/nnis_pkg.sv
// shared types and constants of the nearest neighbor image scaler
package nnis_pkg;

    localparam int SIDE_W      = 11;
    localparam int PIX_W       = 32;
    localparam int COORD_W     = 10;
    localparam int CFG_IDX_W   = 4;
    localparam int PROD_W      = 2 * SIDE_W;
    localparam int DIV_STEPS   = PROD_W;
    localparam int ADDR_MAX_W  = 20;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_DST_WIDTH  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_DST_HEIGHT = CFG_IDX_W'(3);

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_EMIT = 1'b1;

    typedef logic [SIDE_W-1:0] t_side;

    // effective image sides, already clamped to the legal range
    typedef struct packed {
        t_side src_w;
        t_side src_h;
        t_side dst_w;
        t_side dst_h;
    } t_sides;

    typedef struct packed {
        logic             func;
        logic [PIX_W-1:0] src_pixel;
        logic             restart;
    } t_in_item;

    typedef struct packed {
        logic [PIX_W-1:0]   out_pixel;
        logic [COORD_W-1:0] out_x;
        logic [COORD_W-1:0] out_y;
        logic               frame_end;
    } t_out_item;

    // one queued command from the front to the back
    typedef struct packed {
        logic                  is_emit;
        logic [ADDR_MAX_W-1:0] load_addr;
        logic [PIX_W-1:0]      pixel;
        t_side                 x;
        t_side                 y;
        logic                  frame_end;
    } t_cmd;

endpackage

>>> hdl/nearest_neighbor_image_scaler.sv
// top level of the nearest neighbor image scaler
// A load transaction (func 0) writes the next source pixel in raster order into the
// frame store; an emit transaction (func 1) returns the next destination pixel once a
// whole source frame is in. The front accepts one transaction per cycle as long as the
// four-entry command queue has room. In the back a load is written to the store; an
// emit blocks new commands while it forms x*src_width and y*src_height, runs 22
// restoring-divider steps (both axes side by side, one quotient bit each per cycle),
// the store address multiply-add, the registered store read and the result register
// load, which waits on a stalled output. The user must ensure configuration is written
// only while no transaction is in flight; the block does not enforce this. The store
// has no reset or clearing pass: reading an entry never written returns arbitrary data.
module nearest_neighbor_image_scaler #(
    parameter int STORE_PIXELS = 65536,
    parameter int MAX_SIDE     = 1024
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  nnis_pkg::t_in_item             i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output nnis_pkg::t_out_item            o_out_data,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [nnis_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [nnis_pkg::SIDE_W-1:0]    i_cfg_data
);

    nnis_pkg::t_sides w_sides;
    nnis_pkg::t_cmd   w_push_cmd, w_pop_cmd;
    logic             w_push, w_pop, w_empty, w_full;

    nnis_cfg #(
        .MAX_SIDE (MAX_SIDE)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_sides     (w_sides)
    );

    nnis_front #(
        .STORE_PIXELS (STORE_PIXELS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_sides    (w_sides),
        .i_q_full   (w_full),
        .o_push     (w_push),
        .o_cmd      (w_push_cmd)
    );

    nnis_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .i_pop   (w_pop),
        .o_cmd   (w_pop_cmd),
        .o_empty (w_empty),
        .o_full  (w_full)
    );

    nnis_back #(
        .STORE_PIXELS (STORE_PIXELS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_sides     (w_sides),
        .i_empty     (w_empty),
        .i_cmd       (w_pop_cmd),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

>>> hdl/nnis_cfg.sv
// configuration registers of the scaler, stored as clamped image sides
module nnis_cfg #(
    parameter int MAX_SIDE = 1024
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [nnis_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [nnis_pkg::SIDE_W-1:0]      i_cfg_data,
    output nnis_pkg::t_sides                 o_sides
);

    localparam int SIDE_MAX_VAL = (1 << nnis_pkg::SIDE_W) - 1;
    localparam logic [nnis_pkg::SIDE_W-1:0] SIDE_LIMIT =
        (MAX_SIDE > SIDE_MAX_VAL) ? nnis_pkg::SIDE_W'(SIDE_MAX_VAL)
                                  : nnis_pkg::SIDE_W'(MAX_SIDE);

    nnis_pkg::t_sides r_sides;
    nnis_pkg::t_side  w_eff;

    // zero acts as one, oversize acts as the limit
    always_comb begin
        if (i_cfg_data == '0) begin
            w_eff = nnis_pkg::SIDE_W'(1);
        end else if (i_cfg_data > SIDE_LIMIT) begin
            w_eff = SIDE_LIMIT;
        end else begin
            w_eff = i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sides.src_w <= nnis_pkg::SIDE_W'(1);
            r_sides.src_h <= nnis_pkg::SIDE_W'(1);
            r_sides.dst_w <= nnis_pkg::SIDE_W'(1);
            r_sides.dst_h <= nnis_pkg::SIDE_W'(1);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                nnis_pkg::CFG_SRC_WIDTH:  r_sides.src_w <= w_eff;
                nnis_pkg::CFG_SRC_HEIGHT: r_sides.src_h <= w_eff;
                nnis_pkg::CFG_DST_WIDTH:  r_sides.dst_w <= w_eff;
                nnis_pkg::CFG_DST_HEIGHT: r_sides.dst_h <= w_eff;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_sides     = r_sides;

endmodule

>>> hdl/nnis_front.sv
// front end: takes input transactions, tracks load and emit positions, queues work
module nnis_front #(
    parameter int STORE_PIXELS = 65536
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  nnis_pkg::t_in_item i_in_data,
    input  nnis_pkg::t_sides   i_sides,
    input  logic               i_q_full,
    output logic               o_push,
    output nnis_pkg::t_cmd     o_cmd
);

    localparam int LPW = $clog2(STORE_PIXELS + 1);

    logic [LPW-1:0]                r_lp, n_lp;
    nnis_pkg::t_side               r_col, n_col;
    nnis_pkg::t_side               r_row, n_row;

    logic                          w_accept;
    logic [nnis_pkg::PROD_W-1:0]   w_frame;
    logic [LPW-1:0]                w_lp_start;
    logic                          w_load_ok;
    logic                          w_frame_ok;
    nnis_pkg::t_side               w_col0, w_row0, w_x, w_y;
    logic                          w_last_col, w_last_row;

    assign o_in_ready = !i_q_full;
    assign w_accept   = i_in_valid && o_in_ready;

    assign w_frame    = i_sides.src_w * i_sides.src_h;
    assign w_lp_start = i_in_data.restart ? '0 : r_lp;
    assign w_load_ok  = (32'(w_lp_start) < 32'(w_frame)) &&
                        (32'(w_lp_start) < 32'(STORE_PIXELS));
    // emits are answered only once a whole frame that fits is in the store
    assign w_frame_ok = (32'(w_frame) <= 32'(STORE_PIXELS)) &&
                        (32'(r_lp) >= 32'(w_frame));

    assign w_col0 = i_in_data.restart ? '0 : r_col;
    assign w_row0 = i_in_data.restart ? '0 : r_row;

    // a position left outside the frame by a size change falls back to the origin
    always_comb begin
        if (w_col0 >= i_sides.dst_w || w_row0 >= i_sides.dst_h) begin
            w_x = '0;
            w_y = '0;
        end else begin
            w_x = w_col0;
            w_y = w_row0;
        end
    end

    assign w_last_col = (w_x == i_sides.dst_w - nnis_pkg::SIDE_W'(1));
    assign w_last_row = (w_y == i_sides.dst_h - nnis_pkg::SIDE_W'(1));

    always_comb begin
        n_lp  = r_lp;
        n_col = r_col;
        n_row = r_row;
        if (w_accept) begin
            if (i_in_data.func == nnis_pkg::FUNC_LOAD) begin
                n_lp = w_load_ok ? LPW'(w_lp_start + 1'b1) : w_lp_start;
            end else if (!w_frame_ok) begin
                n_col = w_col0;
                n_row = w_row0;
            end else if (!w_last_col) begin
                n_col = w_x + nnis_pkg::SIDE_W'(1);
                n_row = w_y;
            end else begin
                n_col = '0;
                n_row = w_last_row ? '0 : w_y + nnis_pkg::SIDE_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lp  <= '0;
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_lp  <= n_lp;
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    assign o_push = w_accept && ((i_in_data.func == nnis_pkg::FUNC_LOAD) ? w_load_ok
                                                                         : w_frame_ok);

    assign o_cmd.is_emit   = (i_in_data.func == nnis_pkg::FUNC_EMIT);
    assign o_cmd.load_addr = nnis_pkg::ADDR_MAX_W'(w_lp_start);
    assign o_cmd.pixel     = i_in_data.src_pixel;
    assign o_cmd.x         = w_x;
    assign o_cmd.y         = w_y;
    assign o_cmd.frame_end = w_last_col && w_last_row;

endmodule

>>> hdl/nnis_fifo.sv
// short command queue between front and back
module nnis_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  nnis_pkg::t_cmd i_cmd,
    input  logic           i_pop,
    output nnis_pkg::t_cmd o_cmd,
    output logic           o_empty,
    output logic           o_full
);

    localparam int QPW = (nnis_pkg::QUEUE_DEPTH > 1) ? $clog2(nnis_pkg::QUEUE_DEPTH) : 1;
    localparam int QCW = $clog2(nnis_pkg::QUEUE_DEPTH + 1);
    localparam logic [QPW-1:0] LAST_PTR = QPW'(nnis_pkg::QUEUE_DEPTH - 1);
    localparam logic [QCW-1:0] FULL_CNT = QCW'(nnis_pkg::QUEUE_DEPTH);

    nnis_pkg::t_cmd   r_mem [nnis_pkg::QUEUE_DEPTH];
    logic [QPW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [QCW-1:0]   r_count;
    logic             w_push, w_pop;

    assign w_push = i_push && !o_full;
    assign w_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_cmd   = r_mem[r_rd_ptr];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == FULL_CNT);

endmodule

>>> hdl/nnis_back.sv
// back end: frame store, source coordinate divider and result register
module nnis_back #(
    parameter int STORE_PIXELS = 65536
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  nnis_pkg::t_sides    i_sides,
    input  logic                i_empty,
    input  nnis_pkg::t_cmd      i_cmd,
    output logic                o_pop,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output nnis_pkg::t_out_item o_out_data
);

    localparam int AW = (STORE_PIXELS > 1) ? $clog2(STORE_PIXELS) : 1;
    localparam int CW = $clog2(nnis_pkg::DIV_STEPS);
    localparam logic [CW-1:0] LAST_STEP = CW'(nnis_pkg::DIV_STEPS - 1);
    localparam int SW = nnis_pkg::SIDE_W;
    localparam int PW = nnis_pkg::PROD_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_ADDR,
        S_READ,
        S_EMIT
    } t_state;

    logic [nnis_pkg::PIX_W-1:0] r_store [STORE_PIXELS];

    t_state                     r_state;
    logic [CW-1:0]              r_cnt;
    logic [PW-1:0]              r_num_x, r_num_y;
    logic [SW-1:0]              r_rem_x, r_rem_y;
    nnis_pkg::t_side            r_x, r_y;
    logic                       r_end;
    logic [AW-1:0]              r_addr;
    logic [nnis_pkg::PIX_W-1:0] r_rdata;
    logic                       r_out_valid;
    nnis_pkg::t_out_item        r_out;

    logic                       w_we;
    logic                       w_out_load;
    logic [PW-1:0]              w_prod_x, w_prod_y;
    logic [SW:0]                w_tx, w_ty, w_dx, w_dy;
    logic                       w_gex, w_gey;
    nnis_pkg::t_side            w_sx, w_sy;
    logic [PW:0]                w_addr_full;

    assign o_pop = (r_state == S_IDLE) && !i_empty;
    assign w_we  = o_pop && !i_cmd.is_emit;

    // result register takes a new pixel when it is empty or being drained
    assign w_out_load = (r_state == S_EMIT) && (!r_out_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_store[AW'(i_cmd.load_addr)] <= i_cmd.pixel;
        end
        r_rdata <= r_store[r_addr];
    end

    assign w_prod_x = i_cmd.x * i_sides.src_w;
    assign w_prod_y = i_cmd.y * i_sides.src_h;

    // restoring division, one quotient bit per cycle for each axis
    assign w_tx  = {r_rem_x, r_num_x[PW-1]};
    assign w_ty  = {r_rem_y, r_num_y[PW-1]};
    assign w_dx  = w_tx - {1'b0, i_sides.dst_w};
    assign w_dy  = w_ty - {1'b0, i_sides.dst_h};
    assign w_gex = (w_tx >= {1'b0, i_sides.dst_w});
    assign w_gey = (w_ty >= {1'b0, i_sides.dst_h});

    // clamp to the last source column and row
    always_comb begin
        if (r_num_x >= PW'(i_sides.src_w)) begin
            w_sx = i_sides.src_w - SW'(1);
        end else begin
            w_sx = r_num_x[SW-1:0];
        end
        if (r_num_y >= PW'(i_sides.src_h)) begin
            w_sy = i_sides.src_h - SW'(1);
        end else begin
            w_sy = r_num_y[SW-1:0];
        end
    end

    assign w_addr_full = (PW + 1)'(w_sy) * (PW + 1)'(i_sides.src_w) + (PW + 1)'(w_sx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (o_pop && i_cmd.is_emit) begin
                        r_num_x <= w_prod_x;
                        r_num_y <= w_prod_y;
                        r_rem_x <= '0;
                        r_rem_y <= '0;
                        r_x     <= i_cmd.x;
                        r_y     <= i_cmd.y;
                        r_end   <= i_cmd.frame_end;
                        r_cnt   <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem_x <= w_gex ? w_dx[SW-1:0] : w_tx[SW-1:0];
                    r_rem_y <= w_gey ? w_dy[SW-1:0] : w_ty[SW-1:0];
                    r_num_x <= {r_num_x[PW-2:0], w_gex};
                    r_num_y <= {r_num_y[PW-2:0], w_gey};
                    r_cnt   <= r_cnt + 1'b1;
                    if (r_cnt == LAST_STEP) begin
                        r_state <= S_ADDR;
                    end
                end
                S_ADDR: begin
                    r_addr  <= AW'(w_addr_full);
                    r_state <= S_READ;
                end
                S_READ: begin
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (w_out_load) begin
                        r_out.out_pixel <= r_rdata;
                        r_out.out_x     <= r_x[nnis_pkg::COORD_W-1:0];
                        r_out.out_y     <= r_y[nnis_pkg::COORD_W-1:0];
                        r_out.frame_end <= r_end;
                        r_state         <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

>>> hdl/nnis_checker.sv
// port-level assertions for the scaler and their bind to the top level
module nnis_checker #(
    parameter int MAX_SIDE = 1024
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    input  logic                           o_cfg_ready,
    input  logic [nnis_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [nnis_pkg::SIDE_W-1:0]    i_cfg_data,
    input  logic                           o_out_valid,
    input  logic                           i_out_ready,
    input  nnis_pkg::t_out_item            o_out_data
);

    localparam int SIDE_MAX_VAL = (1 << nnis_pkg::SIDE_W) - 1;
    localparam logic [nnis_pkg::SIDE_W-1:0] SIDE_LIMIT =
        (MAX_SIDE > SIDE_MAX_VAL) ? nnis_pkg::SIDE_W'(SIDE_MAX_VAL)
                                  : nnis_pkg::SIDE_W'(MAX_SIDE);

    nnis_pkg::t_side r_dw, r_dh;
    nnis_pkg::t_side w_eff;

    always_comb begin
        if (i_cfg_data == '0) begin
            w_eff = nnis_pkg::SIDE_W'(1);
        end else if (i_cfg_data > SIDE_LIMIT) begin
            w_eff = SIDE_LIMIT;
        end else begin
            w_eff = i_cfg_data;
        end
    end

    // shadow of the destination size as seen on the configuration port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dw <= nnis_pkg::SIDE_W'(1);
            r_dh <= nnis_pkg::SIDE_W'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == nnis_pkg::CFG_DST_WIDTH) begin
                r_dw <= w_eff;
            end
            if (i_cfg_index == nnis_pkg::CFG_DST_HEIGHT) begin
                r_dh <= w_eff;
            end
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result transaction changed");

    a_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ({1'b0, o_out_data.out_x} < r_dw) &&
                        ({1'b0, o_out_data.out_y} < r_dh))
        else $error("emitted position outside destination frame");

    a_frame_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.frame_end |->
            (o_out_data.out_x == nnis_pkg::COORD_W'(r_dw - nnis_pkg::SIDE_W'(1))) &&
            (o_out_data.out_y == nnis_pkg::COORD_W'(r_dh - nnis_pkg::SIDE_W'(1))))
        else $error("frame end flag away from last destination pixel");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

endmodule

bind nearest_neighbor_image_scaler nnis_checker #(
    .MAX_SIDE (MAX_SIDE)
) u_nnis_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_cfg_valid (i_cfg_valid),
    .o_cfg_ready (o_cfg_ready),
    .i_cfg_index (i_cfg_index),
    .i_cfg_data  (i_cfg_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

>>> tb/testbench.sv
`timescale 1ns / 100ps
// self-checking testbench of the nearest neighbor image scaler
module testbench;

    localparam int STORE_PIXELS  = 65536;
    localparam int MAX_SIDE      = 1024;
    localparam int RANDOM_ITEMS  = 500;
    localparam int MIN_PIXELS    = 60;
    localparam int SETTLE_CYCLES = 160;
    localparam int HOLD_CYCLES   = 400;
    localparam int MAX_EMITS     = 300;

    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;
    logic                           in_valid  = 1'b0;
    logic                           in_ready;
    nnis_pkg::t_in_item             in_data   = '0;
    logic                           out_valid;
    logic                           out_ready = 1'b0;
    nnis_pkg::t_out_item            out_data;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [nnis_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    nnis_pkg::t_side                cfg_data  = '0;

    // scaler state as the predictor sees it
    bit [nnis_pkg::PIX_W-1:0] pixel_store [STORE_PIXELS];
    int unsigned              load_pos  = 0;
    int unsigned              emit_col  = 0;
    int unsigned              emit_row  = 0;
    nnis_pkg::t_side          src_w_reg = 1;
    nnis_pkg::t_side          src_h_reg = 1;
    nnis_pkg::t_side          dst_w_reg = 1;
    nnis_pkg::t_side          dst_h_reg = 1;

    nnis_pkg::t_in_item  pending_items [$];
    nnis_pkg::t_out_item expected_pixels [$];
    int unsigned queued_cnt   = 0;
    int unsigned accepted_cnt = 0;
    int unsigned pixels_seen  = 0;
    int unsigned mismatch_cnt = 0;
    bit          in_taken     = 1'b0;
    bit          tx_busy      = 1'b0;
    bit          idle_on      = 1'b0;
    bit          rx_hold_req  = 1'b0;
    int          tx_gap       = 0;
    int          rx_stall     = 0;

    nearest_neighbor_image_scaler #(
        .STORE_PIXELS(STORE_PIXELS),
        .MAX_SIDE    (MAX_SIDE)
    ) i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data (out_data),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data)
    );

    initial begin : clock_gen
        forever #5 clk = ~clk;
    end

    function automatic int unsigned eff_side(nnis_pkg::t_side v);
        if (v == 0) return 1;
        if (v > MAX_SIDE) return MAX_SIDE;
        return 32'(v);
    endfunction

    function automatic int pick_idle();
        int r;
        r = $urandom_range(99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 12);
        return $urandom_range(25, 80);
    endfunction

    function automatic nnis_pkg::t_side pick_src_side();
        if ($urandom_range(99) < 6) return '0;
        return nnis_pkg::t_side'($urandom_range(1, 8));
    endfunction

    function automatic nnis_pkg::t_side pick_dst_side();
        int r;
        r = $urandom_range(99);
        if (r < 5) return '0;
        if (r < 8) return nnis_pkg::t_side'($urandom_range(MAX_SIDE + 1, 2047));
        return nnis_pkg::t_side'($urandom_range(1, 16));
    endfunction

    // advances the scaler state by one transaction and queues the pixel it yields
    task automatic predict_pixel(input nnis_pkg::t_in_item it);
        int unsigned         sw, sh, dw, dh, frame, x, y, sx, sy, addr;
        nnis_pkg::t_out_item res;
        sw    = eff_side(src_w_reg);
        sh    = eff_side(src_h_reg);
        dw    = eff_side(dst_w_reg);
        dh    = eff_side(dst_h_reg);
        frame = sw * sh;
        if (it.func == nnis_pkg::FUNC_LOAD) begin
            if (it.restart) load_pos = 0;
            if (load_pos < frame && load_pos < STORE_PIXELS) begin
                pixel_store[load_pos] = it.src_pixel;
                load_pos++;
            end
            return;
        end
        if (it.restart) begin
            emit_col = 0;
            emit_row = 0;
        end
        if (frame > STORE_PIXELS || load_pos < frame) return;
        x = emit_col;
        y = emit_row;
        // a shrunk destination can leave the position outside the frame
        if (x >= dw || y >= dh) begin
            x = 0;
            y = 0;
        end
        sx = x * sw / dw;
        if (sx >= sw) sx = sw - 1;
        sy = y * sh / dh;
        if (sy >= sh) sy = sh - 1;
        addr = sy * sw + sx;
        res.out_pixel = (addr < STORE_PIXELS) ? pixel_store[addr] : '0;
        res.out_x     = nnis_pkg::COORD_W'(x);
        res.out_y     = nnis_pkg::COORD_W'(y);
        res.frame_end = (x == dw - 1 && y == dh - 1);
        expected_pixels.push_back(res);
        if (x + 1 < dw) begin
            emit_col = x + 1;
            emit_row = y;
        end else begin
            emit_col = 0;
            emit_row = (y + 1 < dh) ? y + 1 : 0;
        end
    endtask

    always @(posedge clk) begin : monitor
        nnis_pkg::t_out_item want;
        if (rst_n) begin
            if (out_valid && out_ready) begin
                pixels_seen++;
                if (expected_pixels.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("%0t: unexpected pixel %h x %0d y %0d end %0b", $time,
                                 out_data.out_pixel, out_data.out_x, out_data.out_y,
                                 out_data.frame_end);
                end else begin
                    want = expected_pixels.pop_front();
                    if (out_data !== want) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10)
                            $display({"%0t: expected pixel %h x %0d y %0d end %0b,",
                                      " got pixel %h x %0d y %0d end %0b"}, $time,
                                     want.out_pixel, want.out_x, want.out_y, want.frame_end,
                                     out_data.out_pixel, out_data.out_x, out_data.out_y,
                                     out_data.frame_end);
                    end
                end
            end
            if (in_valid && in_ready) begin
                predict_pixel(in_data);
                accepted_cnt++;
                in_taken = 1'b1;
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    nnis_pkg::CFG_SRC_WIDTH:  src_w_reg = cfg_data;
                    nnis_pkg::CFG_SRC_HEIGHT: src_h_reg = cfg_data;
                    nnis_pkg::CFG_DST_WIDTH:  dst_w_reg = cfg_data;
                    nnis_pkg::CFG_DST_HEIGHT: dst_h_reg = cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always @(negedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_taken) begin
                in_taken = 1'b0;
                tx_busy  = 1'b0;
                tx_gap   = (idle_on && $urandom_range(99) < 30) ? pick_idle() : 0;
            end
            if (!tx_busy) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                end else if (pending_items.size() != 0) begin
                    in_data <= pending_items.pop_front();
                    tx_busy = 1'b1;
                end
            end
            in_valid <= tx_busy;
        end
    end

    always @(negedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                rx_stall    = HOLD_CYCLES;
            end
            if (rx_stall > 0) begin
                rx_stall--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
                if (idle_on && $urandom_range(99) < 25) rx_stall = pick_idle();
            end
        end
    end

    task automatic push_item(input logic func, input logic [nnis_pkg::PIX_W-1:0] pix,
                             input logic restart);
        nnis_pkg::t_in_item it;
        it.func      = func;
        it.src_pixel = pix;
        it.restart   = restart;
        pending_items.push_back(it);
        queued_cnt++;
    endtask

    task automatic push_frame(input int unsigned pixels);
        for (int unsigned k = 0; k < pixels; k++)
            push_item(nnis_pkg::FUNC_LOAD, $urandom, k == 0);
    endtask

    task automatic push_emits(input int unsigned n, input logic first_restart,
                              input int restart_pct);
        for (int unsigned k = 0; k < n; k++)
            push_item(nnis_pkg::FUNC_EMIT, $urandom,
                      (k == 0) ? first_restart : ($urandom_range(99) < restart_pct));
    endtask

    task automatic write_side(input logic [nnis_pkg::CFG_IDX_W-1:0] idx,
                              input nnis_pkg::t_side val);
        @(negedge clk);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!(cfg_valid && cfg_ready));
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // items are queued right after a rising edge, away from the driver's edge
    task automatic begin_batch(input bit idle);
        @(posedge clk);
        idle_on = idle;
    endtask

    // every transaction taken, every pixel back, then time for trailing loads
    task automatic wait_idle();
        while (!(accepted_cnt == queued_cnt && expected_pixels.size() == 0))
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // a frame larger than the store never completes, so emits stay unanswered
    task automatic run_oversize_frame();
        write_side(nnis_pkg::CFG_SRC_WIDTH, 11'd2047);
        write_side(nnis_pkg::CFG_SRC_HEIGHT, 11'd1024);
        begin_batch(1'b1);
        push_emits(4, 1'b0, 0);
        push_item(nnis_pkg::FUNC_LOAD, $urandom, 1'b0);
        push_item(nnis_pkg::FUNC_LOAD, $urandom, 1'b0);
        push_emits(2, 1'b1, 0);
        wait_idle();
    endtask

    initial begin : stimulus
        int unsigned     frame, n, items_made;
        int              kind;
        bit              reload;
        nnis_pkg::t_side dw, dh;
        items_made = 0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // single pixel frame; emit before any load, load past the frame
        begin_batch(1'b1);
        push_item(nnis_pkg::FUNC_EMIT, 32'h0, 1'b0);
        push_item(nnis_pkg::FUNC_LOAD, 32'hFFFF_FFFF, 1'b1);
        push_item(nnis_pkg::FUNC_EMIT, 32'h0, 1'b0);
        push_item(nnis_pkg::FUNC_EMIT, 32'hFFFF_FFFF, 1'b0);
        push_item(nnis_pkg::FUNC_LOAD, 32'h0, 1'b0);
        push_item(nnis_pkg::FUNC_EMIT, 32'h0, 1'b1);
        wait_idle();

        // zero width acts as one, oversized destination width as the maximum
        write_side(nnis_pkg::CFG_SRC_WIDTH, 11'd0);
        write_side(nnis_pkg::CFG_SRC_HEIGHT, 11'd2);
        write_side(nnis_pkg::CFG_DST_WIDTH, 11'd2047);
        write_side(nnis_pkg::CFG_DST_HEIGHT, 11'd1);
        begin_batch(1'b1);
        push_item(nnis_pkg::FUNC_LOAD, 32'hAAAA_AAAA, 1'b1);
        push_item(nnis_pkg::FUNC_EMIT, 32'h0, 1'b0);
        push_item(nnis_pkg::FUNC_LOAD, 32'h5555_5555, 1'b0);
        push_item(nnis_pkg::FUNC_EMIT, 32'h0, 1'b1);
        push_item(nnis_pkg::FUNC_EMIT, 32'h0, 1'b0);
        push_item(nnis_pkg::FUNC_EMIT, 32'h0, 1'b0);
        wait_idle();

        // shrink the destination under the emit position, then a partial reload
        write_side(nnis_pkg::CFG_DST_WIDTH, 11'd2);
        write_side(nnis_pkg::CFG_DST_HEIGHT, 11'd2);
        begin_batch(1'b1);
        repeat (4) push_item(nnis_pkg::FUNC_EMIT, 32'h0, 1'b0);
        push_item(nnis_pkg::FUNC_LOAD, 32'h0, 1'b1);
        push_item(nnis_pkg::FUNC_EMIT, 32'h0, 1'b0);
        push_item(nnis_pkg::FUNC_LOAD, 32'hFFFF_FFFF, 1'b0);
        push_item(nnis_pkg::FUNC_EMIT, 32'h0, 1'b0);
        wait_idle();

        for (int ph = 0; items_made < RANDOM_ITEMS || pixels_seen < MIN_PIXELS; ph++) begin
            if (ph == 2) begin
                run_oversize_frame();
                continue;
            end
            reload = (ph <= 3) || ($urandom_range(99) < 70);
            if (reload) begin
                write_side(nnis_pkg::CFG_SRC_WIDTH, pick_src_side());
                write_side(nnis_pkg::CFG_SRC_HEIGHT, pick_src_side());
            end
            dw = pick_dst_side();
            dh = pick_dst_side();
            write_side(nnis_pkg::CFG_DST_WIDTH, dw);
            write_side(nnis_pkg::CFG_DST_HEIGHT, dh);
            kind = (ph == 1) ? 0 : $urandom_range(99);
            begin_batch(ph == 1 || $urandom_range(99) < 80);
            if (kind < 75) begin
                frame = eff_side(src_w_reg) * eff_side(src_h_reg);
                if (reload || $urandom_range(1)) begin
                    push_frame(frame);
                    items_made += frame;
                end
                if (ph == 1)
                    n = 24;
                else if ($urandom_range(1))
                    n = eff_side(dw) * eff_side(dh) + $urandom_range(0, 2);
                else
                    n = $urandom_range(1, 20);
                if (n > MAX_EMITS) n = MAX_EMITS;
                push_emits(n, 1'($urandom_range(1)), 3);
                items_made += n;
                // receiver backs off while emits pile up behind it
                if (ph == 1) rx_hold_req = 1'b1;
            end else begin
                n = $urandom_range(10, 40);
                repeat (n) push_item(1'($urandom_range(1)), $urandom,
                                     $urandom_range(99) < 10);
                items_made += n;
            end
            wait_idle();
        end

        wait_idle();
        if (mismatch_cnt == 0 && expected_pixels.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial begin : watchdog
        #20_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
